[rtl/tmv_pkg.sv]
// shared constants, types and saturating helpers of the trend/momentum/volatility signal
// used by tmv_div, the top level and the checker; depends on nothing
package tmv_pkg;

	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_PRICE_BITS = 32;

	localparam int SUM_BITS     = 38;
	localparam int COUNT_BITS   = 8;
	localparam int RSI_BITS     = 15;
	localparam int MUL_B_BITS   = 15;
	localparam int DIV_NUM_BITS = SUM_BITS + MUL_B_BITS;
	localparam int DIV_DEN_BITS = SUM_BITS + 1;
	localparam int CFG_BITS     = 7;
	localparam int CFG_IDX_BITS = 3;
	localparam int NUM_REGS     = 5;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;
	localparam logic [RSI_BITS-1:0]   RSI_FULL  = 15'd25600;
	localparam logic [RSI_BITS-1:0]   RSI_MID   = 15'd12800;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RSI       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RANGE     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_AVG = 3'd4;

	localparam logic [CFG_BITS-1:0] RST_FAST      = 7'd20;
	localparam logic [CFG_BITS-1:0] RST_SLOW      = 7'd50;
	localparam logic [CFG_BITS-1:0] RST_RSI       = 7'd14;
	localparam logic [CFG_BITS-1:0] RST_RANGE     = 7'd14;
	localparam logic [CFG_BITS-1:0] RST_RANGE_AVG = 7'd20;

	localparam logic [1:0] SIG_NONE  = 2'b00;
	localparam logic [1:0] SIG_LONG  = 2'b01;
	localparam logic [1:0] SIG_SHORT = 2'b11;
	localparam logic [1:0] SIG_BAD   = 2'b10;

	typedef struct packed {
		logic                    start;
		logic [DIV_NUM_BITS-1:0] dividend;
		logic [DIV_DEN_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIV_NUM_BITS-1:0] quotient;
	} div_rsp_t;

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [DIV_NUM_BITS-1:0] a,
			input logic [DIV_NUM_BITS-1:0] b);
		logic [DIV_NUM_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[DIV_NUM_BITS:SUM_BITS] != '0)
			return '1;
		return s[SUM_BITS-1:0];
	endfunction

	function automatic logic [SUM_BITS-1:0] sub_floor(input logic [DIV_NUM_BITS-1:0] a,
			input logic [DIV_NUM_BITS-1:0] b);
		logic [DIV_NUM_BITS-1:0] d;
		d = a - b;
		if (b > a)
			return '0;
		return d[SUM_BITS-1:0];
	endfunction

endpackage

[rtl/tmv_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on tmv_pkg for widths and the request/response structs
module tmv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tmv_pkg::div_req_t req,
	output tmv_pkg::div_rsp_t rsp
);
	import tmv_pkg::*;

	localparam int CNT_BITS = $clog2(DIV_NUM_BITS + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [DIV_DEN_BITS-1:0] rem_q;
	logic [DIV_DEN_BITS-1:0] den_q;
	logic [DIV_NUM_BITS-1:0] quo_q;
	logic [DIV_DEN_BITS:0]   trial;
	logic [DIV_DEN_BITS:0]   diff;
	logic                    ge;

	assign trial = {rem_q, quo_q[DIV_NUM_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIV_NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
			quo_q <= {quo_q[DIV_NUM_BITS-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/trend_momentum_volatility_signal.sv]
// One price bar in, one signal item out. A bar passes the sum-update states A0, A1 and A2,
// then seven indicator jobs on the one shared 53-step divider (fast and slow average, ATR,
// average gain, average loss, RSI, ATR average); a job that is not due skips the divider,
// and the ATR average also passes the load state while its window fills. The done state
// then hands over the result once the output register is free. s_tready is high only
// between bars; a finished item waits in the output register while the next bar is taken.
// restart in s_tuser, or a configuration write to one of the five registers, clears the series history.
// Depends on tmv_pkg and tmv_div.
module trend_momentum_volatility_signal #(
	parameter int MAX_WINDOW = tmv_pkg::DEF_MAX_WINDOW,
	parameter int PRICE_BITS = tmv_pkg::DEF_PRICE_BITS,
	localparam int IN_BITS  = ((3 * PRICE_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((4 * PRICE_BITS + 2 + tmv_pkg::RSI_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tmv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tmv_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// bar_high, bar_low, bar_close
	input  logic [IN_BITS-1:0]                s_tdata,
	// restart
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// trade_signal, fast_average, slow_average, rsi_value, range_value, range_average
	output logic [OUT_BITS-1:0]               m_tdata,
	// all_valid
	output logic [0:0]                        m_tuser
);
	import tmv_pkg::*;

	localparam int WB  = $clog2(MAX_WINDOW + 1);
	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int CW  = (WB > CFG_BITS) ? WB : CFG_BITS;
	localparam int IW  = ((WB > COUNT_BITS) ? WB : COUNT_BITS) + 2;
	localparam int P   = PRICE_BITS;
	localparam int NUM = DIV_NUM_BITS;
	localparam int DEN = DIV_DEN_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_A0   = 4'd1;
	localparam logic [3:0] S_A1   = 4'd2;
	localparam logic [3:0] S_A2   = 4'd3;
	localparam logic [3:0] S_PREP = 4'd4;
	localparam logic [3:0] S_LOAD = 4'd5;
	localparam logic [3:0] S_RUN  = 4'd6;
	localparam logic [3:0] S_WB   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	localparam logic [2:0] J_FAST = 3'd0;
	localparam logic [2:0] J_SLOW = 3'd1;
	localparam logic [2:0] J_ATR  = 3'd2;
	localparam logic [2:0] J_GAIN = 3'd3;
	localparam logic [2:0] J_LOSS = 3'd4;
	localparam logic [2:0] J_RSI  = 3'd5;
	localparam logic [2:0] J_AVG  = 3'd6;

	logic [3:0]          state_q;
	logic [2:0]          job_q;
	logic [CFG_BITS-1:0] cfg_q [NUM_REGS];
	logic [WB-1:0]       win [NUM_REGS];

	logic [P-1:0] hi_q, lo_q, cl_q, tr_q, pc_q, cr_q;
	logic [P-1:0] fast_q, slow_q, avg_q;
	logic [RSI_BITS-1:0] rsi_q;
	logic [SUM_BITS-1:0] fast_sum_q, slow_sum_q, seed_q, rws_q, gain_q, loss_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [AW-1:0] ws_q;
	logic [NUM-1:0] mul_q;

	logic [P-1:0] close_mem [MAX_WINDOW];
	logic [P-1:0] range_mem [MAX_WINDOW];
	logic [P-1:0] rdc_q, rdr_q;
	logic [AW-1:0] caddr, raddr;

	logic m_valid_q;
	logic [OUT_BITS-1:0] m_data_q;
	logic m_user_q;

	logic accept, clr, out_go, prep_go, load_go, last_job;
	logic [WB-1:0] wf, ws, wr, wa, wv;
	logic [IW-1:0] iw, wfx, wsx, wrx, wax, wvx;
	logic fv, sv, rv, av, vv, fdrop, sdrop, atr_seed, atr_end, has_prev, g_seed, g_end;
	logic avg_drop, all_ok;
	logic [P-1:0] tr, up, dn, atr_out;
	logic [SUM_BITS-1:0] rws_next;
	logic [SUM_BITS-1:0] mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic [1:0] sig;
	div_req_t div_req;
	div_rsp_t div_rsp;

	function automatic logic [P-1:0] absdiff(input logic [P-1:0] a, input logic [P-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// slot w items back from the write slot
	function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] slot, input logic [WB-1:0] w);
		logic [WB:0] sx, wx, s;
		sx = (WB + 1)'(slot);
		wx = (WB + 1)'(w);
		if (sx >= wx)
			s = sx - wx;
		else
			s = sx + (WB + 1)'(MAX_WINDOW) - wx;
		return s[AW-1:0];
	endfunction

	// window registers: zero acts as one, anything above the history depth as the depth
	always_comb begin
		for (int k = 0; k < NUM_REGS; k++) begin
			if (cfg_q[k] == '0)
				win[k] = WB'(1);
			else if (CW'(cfg_q[k]) > CW'(MAX_WINDOW))
				win[k] = WB'(MAX_WINDOW);
			else
				win[k] = WB'(cfg_q[k]);
		end
	end

	assign wf = win[REG_FAST];
	assign ws = win[REG_SLOW];
	assign wr = win[REG_RSI];
	assign wa = win[REG_RANGE];
	assign wv = win[REG_RANGE_AVG];

	assign iw  = IW'(cnt_q);
	assign wfx = IW'(wf);
	assign wsx = IW'(ws);
	assign wrx = IW'(wr);
	assign wax = IW'(wa);
	assign wvx = IW'(wv);

	assign fv       = (iw + IW'(1)) >= wfx;
	assign sv       = (iw + IW'(1)) >= wsx;
	assign rv       = iw >= wrx;
	assign av       = (iw + IW'(1)) >= wax;
	assign fdrop    = iw >= wfx;
	assign sdrop    = iw >= wsx;
	assign atr_seed = iw < wax;
	assign atr_end  = (iw + IW'(1)) == wax;
	assign has_prev = cnt_q != '0;
	assign g_seed   = iw <= wrx;
	assign g_end    = iw == wrx;
	// ATR values so far is i + 2 - range_window
	assign avg_drop = (iw + IW'(2)) > (wax + wvx);
	assign vv       = av && ((iw + IW'(2)) >= (wax + wvx));
	assign all_ok   = fv && sv && rv && av && vv;

	always_comb begin
		tr = absdiff(hi_q, lo_q);
		if (has_prev) begin
			if (absdiff(hi_q, pc_q) > tr)
				tr = absdiff(hi_q, pc_q);
			if (absdiff(lo_q, pc_q) > tr)
				tr = absdiff(lo_q, pc_q);
		end
	end

	assign up = (cl_q > pc_q) ? cl_q - pc_q : '0;
	assign dn = (cl_q < pc_q) ? pc_q - cl_q : '0;

	assign caddr = (state_q == S_A0) ? back_slot(ws_q, wf) : back_slot(ws_q, ws);
	assign raddr = back_slot(ws_q, wv);

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign clr      = (cfg_we && (cfg_index < NUM_REGS)) || (accept && s_tuser[0]);
	assign out_go   = !m_valid_q || m_tready;
	assign last_job = job_q == J_AVG;

	assign rws_next = avg_drop ? sub_floor(NUM'(rws_q), NUM'(rdr_q)) : rws_q;
	assign atr_out  = av ? cr_q : '0;

	// whether a job divides this bar
	always_comb begin
		case (job_q)
			J_FAST: prep_go = fv;
			J_SLOW: prep_go = sv;
			J_ATR:  prep_go = atr_seed ? atr_end : 1'b1;
			J_GAIN: prep_go = has_prev && (g_end || !g_seed);
			J_LOSS: prep_go = has_prev && (g_end || !g_seed);
			J_RSI:  prep_go = rv && (loss_q != '0);
			J_AVG:  prep_go = av;
			default: prep_go = 1'b0;
		endcase
	end

	assign load_go = (job_q == J_AVG) ? vv : 1'b1;

	always_comb begin
		case (job_q)
			J_ATR: begin
				mul_a = SUM_BITS'(cr_q);
				mul_b = MUL_B_BITS'(wa) - 1'b1;
			end
			J_GAIN: begin
				mul_a = gain_q;
				mul_b = MUL_B_BITS'(wr) - 1'b1;
			end
			J_LOSS: begin
				mul_a = loss_q;
				mul_b = MUL_B_BITS'(wr) - 1'b1;
			end
			default: begin
				mul_a = gain_q;
				mul_b = MUL_B_BITS'(RSI_FULL);
			end
		endcase
	end

	always_comb begin
		div_req.start = (state_q == S_LOAD) && load_go;
		case (job_q)
			J_FAST: begin
				div_req.dividend = NUM'(fast_sum_q);
				div_req.divisor  = DEN'(wf);
			end
			J_SLOW: begin
				div_req.dividend = NUM'(slow_sum_q);
				div_req.divisor  = DEN'(ws);
			end
			J_ATR: begin
				div_req.dividend = atr_seed ? NUM'(seed_q) : NUM'(sat_add(mul_q, NUM'(tr_q)));
				div_req.divisor  = DEN'(wa);
			end
			J_GAIN: begin
				div_req.dividend = g_end ? NUM'(gain_q) : NUM'(sat_add(mul_q, NUM'(up)));
				div_req.divisor  = DEN'(wr);
			end
			J_LOSS: begin
				div_req.dividend = g_end ? NUM'(loss_q) : NUM'(sat_add(mul_q, NUM'(dn)));
				div_req.divisor  = DEN'(wr);
			end
			J_RSI: begin
				div_req.dividend = mul_q;
				div_req.divisor  = DEN'(gain_q) + DEN'(loss_q);
			end
			default: begin
				div_req.dividend = NUM'(rws_next);
				div_req.divisor  = DEN'(wv);
			end
		endcase
	end

	tmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		sig = SIG_NONE;
		if (all_ok && (cr_q > avg_q)) begin
			if ((fast_q > slow_q) && (rsi_q > RSI_MID))
				sig = SIG_LONG;
			else if ((fast_q < slow_q) && (rsi_q < RSI_MID))
				sig = SIG_SHORT;
		end
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= J_FAST;
			m_valid_q <= 1'b0;
			cfg_q[REG_FAST]      <= RST_FAST;
			cfg_q[REG_SLOW]      <= RST_SLOW;
			cfg_q[REG_RSI]       <= RST_RSI;
			cfg_q[REG_RANGE]     <= RST_RANGE;
			cfg_q[REG_RANGE_AVG] <= RST_RANGE_AVG;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FAST:      cfg_q[REG_FAST]      <= cfg_data;
					REG_SLOW:      cfg_q[REG_SLOW]      <= cfg_data;
					REG_RSI:       cfg_q[REG_RSI]       <= cfg_data;
					REG_RANGE:     cfg_q[REG_RANGE]     <= cfg_data;
					REG_RANGE_AVG: cfg_q[REG_RANGE_AVG] <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == S_DONE) && out_go)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) state_q <= S_A0;
				S_A0: state_q <= S_A1;
				S_A1: state_q <= S_A2;
				S_A2: begin
					state_q <= S_PREP;
					job_q   <= J_FAST;
				end
				S_PREP: begin
					if (prep_go)
						state_q <= S_LOAD;
					else if (last_job)
						state_q <= S_DONE;
					else begin
						job_q   <= job_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_LOAD: begin
					if (load_go)
						state_q <= S_RUN;
					else if (last_job)
						state_q <= S_DONE;
					else begin
						job_q   <= job_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_RUN: if (div_rsp.done) state_q <= S_WB;
				S_WB: begin
					if (last_job)
						state_q <= S_DONE;
					else begin
						job_q   <= job_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_DONE: begin
					if (out_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
			seed_q     <= '0;
			rws_q      <= '0;
			gain_q     <= '0;
			loss_q     <= '0;
			cr_q       <= '0;
			pc_q       <= '0;
			cnt_q      <= '0;
			ws_q       <= '0;
		end else if (clr) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
			seed_q     <= '0;
			rws_q      <= '0;
			gain_q     <= '0;
			loss_q     <= '0;
			cr_q       <= '0;
			pc_q       <= '0;
			cnt_q      <= '0;
			ws_q       <= '0;
		end else begin
			case (state_q)
				S_A0: begin
					fast_sum_q <= sat_add(NUM'(fast_sum_q), NUM'(cl_q));
					slow_sum_q <= sat_add(NUM'(slow_sum_q), NUM'(cl_q));
				end
				S_A1: begin
					if (fdrop)
						fast_sum_q <= sub_floor(NUM'(fast_sum_q), NUM'(rdc_q));
					if (atr_seed)
						seed_q <= sat_add(NUM'(seed_q), NUM'(tr_q));
					if (has_prev && g_seed) begin
						gain_q <= sat_add(NUM'(gain_q), NUM'(up));
						loss_q <= sat_add(NUM'(loss_q), NUM'(dn));
					end
				end
				S_A2: begin
					if (sdrop)
						slow_sum_q <= sub_floor(NUM'(slow_sum_q), NUM'(rdc_q));
				end
				S_PREP: begin
					if ((job_q == J_AVG) && av)
						rws_q <= sat_add(NUM'(rws_q), NUM'(cr_q));
				end
				S_LOAD: begin
					if (job_q == J_AVG)
						rws_q <= rws_next;
				end
				S_WB: begin
					case (job_q)
						J_ATR:  cr_q   <= div_rsp.quotient[P-1:0];
						J_GAIN: gain_q <= div_rsp.quotient[SUM_BITS-1:0];
						J_LOSS: loss_q <= div_rsp.quotient[SUM_BITS-1:0];
						default: ;
					endcase
				end
				S_DONE: begin
					if (out_go) begin
						pc_q <= cl_q;
						if (cnt_q != COUNT_MAX)
							cnt_q <= cnt_q + 1'b1;
						ws_q <= (ws_q == AW'(MAX_WINDOW - 1)) ? '0 : ws_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// bar payload, products, indicator values and the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= s_tdata[P-1:0];
			lo_q <= s_tdata[2*P-1:P];
			cl_q <= s_tdata[3*P-1:2*P];
		end
		if (state_q == S_A0)
			tr_q <= tr;
		if (state_q == S_PREP) begin
			mul_q <= NUM'(mul_a) * NUM'(mul_b);
			if (!prep_go) begin
				case (job_q)
					J_FAST: fast_q <= '0;
					J_SLOW: slow_q <= '0;
					J_RSI:  rsi_q  <= rv ? RSI_FULL : '0;
					J_AVG:  avg_q  <= '0;
					default: ;
				endcase
			end
		end
		if ((state_q == S_LOAD) && !load_go)
			avg_q <= '0;
		if (state_q == S_WB) begin
			case (job_q)
				J_FAST: fast_q <= div_rsp.quotient[P-1:0];
				J_SLOW: slow_q <= div_rsp.quotient[P-1:0];
				J_RSI:  rsi_q  <= div_rsp.quotient[RSI_BITS-1:0];
				J_AVG:  avg_q  <= div_rsp.quotient[P-1:0];
				default: ;
			endcase
		end
		if ((state_q == S_DONE) && out_go) begin
			m_data_q <= OUT_BITS'({avg_q, atr_out, rsi_q, slow_q, fast_q, sig});
			m_user_q <= all_ok;
		end
	end

	// close and ATR history rings
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_go) begin
			close_mem[ws_q] <= cl_q;
			range_mem[ws_q] <= atr_out;
		end
		rdc_q <= close_mem[caddr];
		rdr_q <= range_mem[raddr];
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

endmodule

[rtl/tmv_checker.sv]
// port-level checks of the trend/momentum/volatility signal block, bound to the top level
// depends on tmv_pkg and trend_momentum_volatility_signal
module tmv_checker #(
	parameter int PRICE_BITS = tmv_pkg::DEF_PRICE_BITS,
	localparam int OUT_BITS = ((4 * PRICE_BITS + 2 + tmv_pkg::RSI_BITS + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_BITS-1:0] m_tdata,
	input logic [0:0]          m_tuser
);
	import tmv_pkg::*;

	localparam int RSI_LO = 2 + 2 * PRICE_BITS;

	logic [1:0]          sig;
	logic [RSI_BITS-1:0] rsi;

	assign sig = m_tdata[1:0];
	assign rsi = m_tdata[RSI_LO + RSI_BITS - 1:RSI_LO];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output item changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a bar is in work");

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output item without a bar in work");

	a_sig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (sig != SIG_NONE) |-> m_tuser[0] && (sig != SIG_BAD))
		else $error("signal given before warm-up or bad code");

	a_rsi: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> rsi <= RSI_FULL)
		else $error("rsi out of range");

endmodule

bind trend_momentum_volatility_signal tmv_checker #(.PRICE_BITS(PRICE_BITS)) u_tmv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
